// File: hw/rtl/mtep_pkg.sv
// Package for the MIDI track event parser: phase codes, event kinds, error codes,
// the queue entry type and the message size table. It has no dependencies.
package mtep_pkg;

   typedef enum logic [3:0] {
      PH_DELTA     = 4'd0,
      PH_STATUS    = 4'd1,
      PH_META_ID   = 4'd2,
      PH_LEN       = 4'd3,
      PH_DATA      = 4'd4,
      PH_ESC_FIRST = 4'd5,
      PH_SYX       = 4'd6,
      PH_SKIP      = 4'd7,
      PH_DONE      = 4'd8,
      PH_ERROR     = 4'd9
   } phase_type;

   localparam logic [1:0] KIND_MSG  = 2'd0;
   localparam logic [1:0] KIND_META = 2'd1;
   localparam logic [1:0] KIND_ESC  = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_SIZE = 2'd1;
   localparam logic [1:0] ERR_VLQ  = 2'd2;

   localparam logic [7:0] BYTE_META  = 8'hFF;
   localparam logic [7:0] BYTE_ESC   = 8'hF7;
   localparam logic [7:0] BYTE_SYSEX = 8'hF0;
   localparam logic [7:0] META_EOT   = 8'h2F;
   localparam logic [7:0] META_EOT2  = 8'h3F;

   // One result item as it travels from the front part to the back part.
   typedef struct packed {
      logic [1:0]  kind;
      logic [27:0] delta;
      logic [7:0]  data;
      logic        present;
      logic        first;
      logic        last;
      logic        eot;
      logic [1:0]  err;
   } rsp_type;

   // One accepted byte's worth of results: zero, one or two items.
   typedef struct packed {
      logic    has0;
      logic    has1;
      rsp_type r0;
      rsp_type r1;
   } pair_type;

   function automatic logic [1:0] msg_size(input logic [7:0] id);
      logic [1:0] s;
      s = 2'd0;
      if (id[7]) begin
         if (id[7:4] != 4'hF) begin
            unique case (id[6:4]) inside
               3'd4, 3'd5: s = 2'd2;
               3'd7:       s = 2'd0;
               default:    s = 2'd3;
            endcase
         end else begin
            unique case (id[3:0]) inside
               4'd1, 4'd3: s = 2'd2;
               4'd2:       s = 2'd3;
               4'd0, 4'd7: s = 2'd0;
               default:    s = 2'd1;
            endcase
         end
      end
      return s;
   endfunction

endpackage

// File: hw/rtl/midi_track_event_parser_core.sv
// MIDI track event parser. Track chunk bytes enter one per cycle on the req_ stream,
// with req_tuser marking the first byte of each track. Every event byte leaves on the
// rsp_ stream tagged with its delta time, kind and first/last marks; the kind travels
// on rsp_tuser and the last mark of an event on rsp_tlast. An accepted byte yields
// zero, one or two results. Input bytes are taken every cycle as long as the
// four-entry result queue has room for two results, so the sustained rate is one byte
// per cycle when the output side keeps up; the queue depth sets how far the output may
// stall before input stalls. Results can be transferred from the cycle after the byte
// that causes them.
// Depends on mtep_pkg, mtep_front and mtep_queue.
module midi_track_event_parser_core import mtep_pkg::*; #(
   parameter int VLQ_MAX_BYTES = 4,
   parameter int LENGTH_BITS   = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // track_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [27:0] delta_time, [35:28] event_byte, [36] byte_present, [37] first_of_event,
   // [38] end_of_track, [40:39] error_code
   output logic [47:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast    // last_of_event
);

   pair_type pair;
   rsp_type  head;
   logic     room;
   logic     step;

   // A byte is accepted whenever the queue can absorb its worst-case two results.
   assign req_tready = room;
   assign step       = req_tvalid && req_tready;

   mtep_front #(
      .VLQ_MAX_BYTES(VLQ_MAX_BYTES),
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .step(step),
      .data_byte(req_tdata),
      .track_start(req_tuser),
      .pair(pair)
   );

   mtep_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(step),
      .pair(pair),
      .has_room(room),
      .pop_valid(rsp_tvalid),
      .pop_data(head),
      .pop(rsp_tready)
   );

   assign rsp_tdata = {7'd0, head.err, head.eot, head.first, head.present,
                       head.data, head.delta};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// File: hw/rtl/mtep_front.sv
// Front part of the MIDI track event parser: takes one byte per cycle on step, tracks
// the parse phase and produces up to two result items per byte. Depends on mtep_pkg.
module mtep_front import mtep_pkg::*; #(
   parameter int VLQ_MAX_BYTES = 4,
   parameter int LENGTH_BITS   = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       track_start,
   output pair_type   pair
);

   localparam int CW = $clog2(VLQ_MAX_BYTES + 1);

   phase_type              phase_ff, phase_in;
   logic [7:0]             run_ff, run_in;
   logic [7:0]             id_ff, id_in;
   logic [27:0]            delta_ff, delta_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [1:0]             kind_ff, kind_in;
   logic                   closed_ff, closed_in;
   rsp_type                res0, res1;
   logic [1:0]             res_count;

   always_comb begin
      phase_type              ph;
      logic [CW-1:0]          cnt;
      logic [27:0]            dl;
      logic [LENGTH_BITS-1:0] lf;
      logic [LENGTH_BITS-1:0] lnew;
      logic                   cl;
      logic [7:0]             id;
      logic [1:0]             sz;
      logic                   reuse;
      logic                   nz;
      logic [CW:0]            cn;
      int                     n;
      rsp_type                q [2];

      ph = phase_ff; cnt = cnt_ff; dl = delta_ff; lf = left_ff; cl = closed_ff;
      if (track_start) begin
         ph = PH_DELTA; cnt = '0; dl = '0; lf = '0; cl = 1'b0;
      end
      phase_in = ph; run_in = run_ff; id_in = id_ff; kind_in = kind_ff;
      cnt_in = cnt; delta_in = dl; left_in = lf; closed_in = cl;
      n = 0;
      q[0] = '0; q[1] = '0;
      id = '0; sz = '0; reuse = 1'b0; nz = 1'b0; cn = '0; lnew = '0;

      unique case (ph) inside
         PH_DELTA, PH_STATUS: begin
            if (ph == PH_STATUS) begin
               if (data_byte == BYTE_META) begin
                  kind_in = KIND_META; phase_in = PH_META_ID;
               end else if (data_byte == BYTE_ESC || data_byte == BYTE_SYSEX) begin
                  kind_in = (data_byte == BYTE_ESC) ? KIND_ESC : KIND_MSG;
                  left_in = '0; cnt_in = '0; phase_in = PH_LEN;
               end else begin
                  kind_in = KIND_MSG;
                  reuse = ~data_byte[7];
                  id = reuse ? run_ff : data_byte;
                  run_in = id;
                  sz = msg_size(id);
                  if (sz == 2'd0) begin
                     q[0] = '{KIND_ERR, 28'd0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_SIZE};
                     n = 1; phase_in = PH_ERROR;
                  end else begin
                     q[0] = '{KIND_MSG, dl, id, 1'b1, 1'b1, sz == 2'd1, 1'b0, ERR_NONE};
                     n = 1;
                     if (sz == 2'd1) begin
                        phase_in = PH_DELTA; cnt_in = '0;
                     end else if (reuse) begin
                        left_in = LENGTH_BITS'(sz - 2'd2);
                        q[1] = '{KIND_MSG, dl, data_byte, 1'b1, 1'b0, sz == 2'd2,
                                 1'b0, ERR_NONE};
                        n = 2;
                        phase_in = (sz == 2'd2) ? PH_DELTA : PH_DATA;
                     end else begin
                        left_in = LENGTH_BITS'(sz - 2'd1);
                        phase_in = PH_DATA;
                     end
                  end
               end
            end
            // Delta byte, also for a one-byte message's running-status data.
            // That data byte has bit 7 clear, so the error report below can
            // only come from a true delta byte, which has no other result.
            if (ph == PH_DELTA || (reuse && sz == 2'd1)) begin
               cnt = (ph == PH_DELTA) ? cnt : '0;
               dl = (cnt == '0) ? {21'd0, data_byte[6:0]} : {dl[20:0], data_byte[6:0]};
               delta_in = dl;
               cn = {1'b0, cnt} + 1'b1;
               cnt_in = cn[CW-1:0];
               if (data_byte[7]) begin
                  if (cn >= (CW+1)'(VLQ_MAX_BYTES)) begin
                     q[0] = '{KIND_ERR, 28'd0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_VLQ};
                     n = 1; phase_in = PH_ERROR;
                  end
               end else begin
                  cnt_in = '0; phase_in = PH_STATUS;
               end
            end
         end
         PH_META_ID: begin
            id_in = data_byte;
            if (data_byte == META_EOT || data_byte == META_EOT2) begin
               q[0] = '{KIND_META, dl, data_byte, 1'b1, 1'b1, 1'b1, 1'b1, ERR_NONE};
               n = 1; phase_in = PH_DONE;
            end else begin
               left_in = '0; cnt_in = '0; phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            lnew = LENGTH_BITS'({lf, data_byte[6:0]});
            left_in = lnew;
            cn = {1'b0, cnt} + 1'b1;
            cnt_in = cn[CW-1:0];
            nz = (lnew != '0);
            if (data_byte[7]) begin
               if (cn >= (CW+1)'(VLQ_MAX_BYTES)) begin
                  q[0] = '{KIND_ERR, 28'd0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_VLQ};
                  n = 1; phase_in = PH_ERROR;
               end
            end else begin
               cnt_in = '0;
               if (kind_ff == KIND_META) begin
                  q[0] = '{KIND_META, dl, id_ff, 1'b1, 1'b1, ~nz, 1'b0, ERR_NONE};
                  n = 1; phase_in = nz ? PH_DATA : PH_DELTA;
               end else if (kind_ff == KIND_ESC) begin
                  if (!nz) begin
                     q[0] = '{KIND_ESC, dl, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0, ERR_NONE};
                     n = 1; phase_in = PH_DELTA;
                  end else begin
                     phase_in = PH_ESC_FIRST;
                  end
               end else begin
                  closed_in = 1'b0;
                  q[0] = '{KIND_MSG, dl, BYTE_SYSEX, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE};
                  n = 1;
                  if (!nz) begin
                     q[1] = '{KIND_MSG, dl, BYTE_ESC, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE};
                     n = 2; phase_in = PH_DELTA;
                  end else begin
                     phase_in = PH_SYX;
                  end
               end
            end
         end
         PH_DATA, PH_ESC_FIRST, PH_SYX, PH_SKIP: begin
            if (lf != '0) lf = lf - 1'b1;
            left_in = lf;
            nz = (lf != '0);
            if (ph == PH_SKIP) begin
               if (!nz) phase_in = PH_DELTA;
            end else if (ph != PH_SYX) begin
               q[0] = '{kind_ff, dl, data_byte, 1'b1, ph == PH_ESC_FIRST, ~nz, 1'b0,
                        ERR_NONE};
               n = 1; phase_in = nz ? PH_DATA : PH_DELTA;
            end else if (!cl) begin
               if (data_byte == BYTE_ESC) begin
                  q[0] = '{KIND_MSG, dl, data_byte, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE};
                  n = 1;
                  if (!nz) phase_in = PH_DELTA;
                  else closed_in = 1'b1;
               end else begin
                  q[0] = '{KIND_MSG, dl, data_byte, 1'b1, 1'b0, 1'b0, 1'b0, ERR_NONE};
                  n = 1;
                  if (!nz) begin
                     q[1] = '{KIND_MSG, dl, BYTE_ESC, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE};
                     n = 2; phase_in = PH_DELTA;
                  end
               end
            end else if (data_byte == BYTE_SYSEX) begin
               closed_in = 1'b0;
               q[0] = '{KIND_MSG, dl, data_byte, 1'b1, 1'b1, 1'b0, 1'b0, ERR_NONE};
               n = 1;
               if (!nz) begin
                  q[1] = '{KIND_MSG, dl, BYTE_ESC, 1'b1, 1'b0, 1'b1, 1'b0, ERR_NONE};
                  n = 2; phase_in = PH_DELTA;
               end
            end else begin
               phase_in = nz ? PH_SKIP : PH_DELTA;
            end
         end
         default: ;
      endcase

      res0      = q[0];
      res1      = q[1];
      res_count = 2'(n);
   end

   always_comb begin
      pair.has0 = (res_count != 2'd0);
      pair.has1 = (res_count == 2'd2);
      pair.r0   = res0;
      pair.r1   = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA; run_ff <= '0; id_ff <= '0; delta_ff <= '0;
         cnt_ff <= '0; left_ff <= '0; kind_ff <= '0; closed_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; run_ff <= run_in; id_ff <= id_in; delta_ff <= delta_in;
         cnt_ff <= cnt_in; left_ff <= left_in; kind_ff <= kind_in; closed_ff <= closed_in;
      end
   end

   a_err_state_holds: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_ERROR && !track_start) |=> phase_ff == PH_ERROR)
      else $error("error state left without a track start");
   a_two_needs_one: assert property (@(posedge clock) disable iff (reset)
      pair.has1 |-> pair.has0)
      else $error("second result without a first");
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !track_start) |-> !pair.has0)
      else $error("result after end of track");

endmodule

// File: hw/rtl/mtep_queue.sv
// Result queue between the parser front part and the output stage. Accepts up to two
// entries per cycle and releases one. Depends on mtep_pkg.
module mtep_queue import mtep_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pair_type pair,
   output logic    has_room,
   output logic    pop_valid,
   output rsp_type pop_data,
   input  logic    pop
);

   localparam int DEPTH = 4;

   rsp_type    mem_ff [DEPTH];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] nw;

   assign nw        = push ? {1'b0, pair.has0} + {1'b0, pair.has1} : 2'd0;
   assign pop_valid = (cnt_ff != 3'd0);
   assign pop_data  = mem_ff[rd_ff];
   // Room for two more entries whatever the output side does.
   assign has_room  = (cnt_ff <= 3'd2);

   always_comb begin
      wr_in  = wr_ff + nw;
      rd_in  = rd_ff + {1'b0, (pop && pop_valid)};
      cnt_in = cnt_ff + {1'b0, nw} - {2'b0, (pop && pop_valid)};
   end

   always_ff @(posedge clock) begin
      if (push && pair.has0) mem_ff[wr_ff] <= pair.r0;
      if (push && pair.has1) mem_ff[wr_ff + 2'd1] <= pair.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(DEPTH))
      else $error("result queue overflow");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push |-> has_room)
      else $error("push into a full queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(cnt_ff))
      else $error("queue count moved without traffic");

endmodule
